// ===== hw/rtl/kmsm_pkg.sv =====
// ============================================================================
// kmsm_pkg: shared types and constants of the k-mismatch stream matcher
// Item and result layouts, operation and register codes, cell control.
// ============================================================================
package kmsm_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int REG_W       = 7;
    localparam int POS_W       = 32;
    localparam int COUNT_W     = 7;
    localparam int REG_INDEX_W = 1;

    typedef logic [SYMBOL_W-1:0]    symbol_t;
    typedef logic [REG_INDEX_W-1:0] reg_index_t;

    // Operation codes carried by an input item.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    // Configuration register indexes.
    localparam reg_index_t REG_MISMATCH_LIMIT = 1'd0;
    localparam reg_index_t REG_PATTERN_LENGTH = 1'd1;

    // Largest value the mismatch count field can carry.
    localparam logic [COUNT_W-1:0] COUNT_FIELD_MAX = 7'd127;

    typedef struct packed {
        logic    operation;
        symbol_t symbol;
        logic    last_item;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   alignment_position;
        logic [COUNT_W-1:0] mismatch_count;
        logic               within_limit;
        logic               last_result;
    } result_t;

    // Control shared by every cell of the row.
    typedef struct packed {
        logic shift;    // a text byte enters the window
        logic compare;  // capture the mismatch flag for the current window
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/kmsm_stream_if.sv =====
// ============================================================================
// kmsm_stream_if: valid/ready stream channel
// Carries one payload per transfer; the source drives valid and data.
// ============================================================================
interface kmsm_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/k_mismatch_stream_matcher_unit.sv =====
// ============================================================================
// k_mismatch_stream_matcher_unit: k-mismatch pattern matcher over a byte stream
// Pattern bytes load into a row of cells; text bytes shift through the row
// and every full alignment yields its start position and mismatch count.
//
//   channel   direction  payload                                  transfer when
//   items     in         operation, symbol, last_item             valid & ready
//   results   out        alignment_position, mismatch_count,      valid & ready
//                        within_limit, last_result
//   cfg       in         cfg_index, cfg_data                      cfg_we
//
// One item is taken per cycle while no held result stalls the input. A
// result passes from its text byte through the window register, the cell
// compare stage, the group count stage and the output register.
// Reset clears the window, counters and valid flags; no clearing pass.
// A result held in the output register stalls the whole pipeline and input.
// ============================================================================
module k_mismatch_stream_matcher_unit #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    kmsm_stream_if.sink                items,
    kmsm_stream_if.source              results,
    input  logic                       cfg_we,
    input  kmsm_pkg::reg_index_t       cfg_index,
    input  logic [kmsm_pkg::REG_W-1:0] cfg_data
);
    import kmsm_pkg::*;

    localparam int MW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] start;
        logic             last;
    } tag_t;

    logic [REG_W-1:0]   limit_reg;
    logic [REG_W-1:0]   length_reg;
    logic [MW-1:0]      used_length;

    item_t              item;
    logic               advance;
    logic               accept;
    logic               text_accept;
    logic               pattern_load;

    logic [POS_W-1:0]   text_count_reg;
    logic [POS_W-1:0]   text_count_next;
    logic [POS_W-1:0]   count_inc;
    logic               emit;

    logic [IW-1:0]      load_idx_reg;
    logic [IW-1:0]      load_idx_next;

    tag_t               s0_reg;
    tag_t               s1_reg;
    tag_t               s2_reg;
    tag_t               s0_next;

    cell_ctrl_t         cell_ctrl;
    symbol_t            text_chain [PATTERN_MAX+1];
    symbol_t            window     [PATTERN_MAX];
    symbol_t            aligned    [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] flags;
    logic [MW-1:0]      total;

    logic [COUNT_W-1:0] cap;
    logic [COUNT_W-1:0] count_sat;
    logic               out_valid_reg;
    result_t            out_data_reg;
    result_t            out_data_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= '0;
            length_reg <= REG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MISMATCH_LIMIT: limit_reg  <= cfg_data;
                REG_PATTERN_LENGTH: length_reg <= cfg_data;
                default:            limit_reg  <= limit_reg;
            endcase
        end
    end

    // Effective pattern length, clamped to one through the row length.
    always_comb
    begin
        priority if (length_reg == '0)
        begin
            used_length = MW'(1);
        end
        else if (32'(length_reg) > 32'(PATTERN_MAX))
        begin
            used_length = MW'(PATTERN_MAX);
        end
        else
        begin
            used_length = MW'(length_reg);
        end
    end

    // Input transfer; the pipeline moves whenever the output can take a result.
    assign item         = items.data;
    assign advance      = !out_valid_reg || results.ready;
    assign items.ready  = advance;
    assign accept       = items.valid && advance;
    assign text_accept  = accept && (item.operation == OP_TEXT);
    assign pattern_load = accept && (item.operation == OP_LOAD);

    // Text position, saturating at its maximum.
    assign count_inc = (text_count_reg == '1) ? text_count_reg : text_count_reg + 32'd1;
    assign emit      = (count_inc >= 32'(used_length));

    always_comb
    begin
        text_count_next = text_count_reg;
        if (text_accept)
        begin
            text_count_next = item.last_item ? '0 : count_inc;
        end
    end

    // Pattern load slot wraps at the row end or after a marked last byte.
    always_comb
    begin
        load_idx_next = load_idx_reg;
        if (pattern_load)
        begin
            if (item.last_item || (load_idx_reg == IW'(PATTERN_MAX - 1)))
            begin
                load_idx_next = '0;
            end
            else
            begin
                load_idx_next = load_idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_count_reg <= '0;
            load_idx_reg   <= '0;
        end
        else
        begin
            text_count_reg <= text_count_next;
            load_idx_reg   <= load_idx_next;
        end
    end

    // Tag of the alignment traveling alongside the compare and count stages.
    always_comb
    begin
        s0_next.valid = text_accept && emit;
        s0_next.start = count_inc - 32'(used_length);
        s0_next.last  = item.last_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (advance)
        begin
            s0_reg <= s0_next;
            s1_reg <= s0_reg;
            s2_reg <= s1_reg;
        end
    end

    // Row of cells: the window moves one cell on each text byte.
    assign cell_ctrl.shift   = text_accept;
    assign cell_ctrl.compare = advance;
    assign text_chain[0]     = item.symbol;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        kmsm_cell #(
            .INDEX (j),
            .MW    (MW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .load        (pattern_load && (load_idx_reg == IW'(j))),
            .load_symbol (item.symbol),
            .text_in     (text_chain[j]),
            .text_out    (text_chain[j+1]),
            .aligned     (aligned[j]),
            .used_length (used_length),
            .mismatch    (flags[j])
        );

        assign window[j] = text_chain[j+1];
    end

    kmsm_align #(
        .PATTERN_MAX (PATTERN_MAX),
        .MW          (MW)
    ) u_align (
        .window      (window),
        .used_length (used_length),
        .aligned     (aligned)
    );

    kmsm_count #(
        .PATTERN_MAX (PATTERN_MAX),
        .MW          (MW)
    ) u_count (
        .clk     (clk),
        .advance (advance),
        .flags   (flags),
        .total   (total)
    );

    // Count saturates at the limit plus one, never past the field maximum.
    assign cap       = (limit_reg == COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : limit_reg + 7'd1;
    assign count_sat = (32'(total) > 32'(cap)) ? cap : COUNT_W'(total);

    always_comb
    begin
        out_data_next.alignment_position = s2_reg.start;
        out_data_next.mismatch_count     = count_sat;
        out_data_next.within_limit       = (count_sat <= limit_reg);
        out_data_next.last_result        = s2_reg.last;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // The reported count never passes the saturation point.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.data.mismatch_count <= cap))
        else $error("mismatch count above saturation point");

    // The match flag agrees with the count and the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |->
            (results.data.within_limit == (results.data.mismatch_count <= limit_reg)))
        else $error("match flag disagrees with count");

    // A pattern load never starts an alignment.
    assert property (@(posedge clk) disable iff (!rst_n)
        pattern_load |=> !s0_reg.valid)
        else $error("pattern load produced an alignment");

    // The text position restarts after the last text byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (text_accept && item.last_item) |=> (text_count_reg == '0))
        else $error("text position not restarted");

    // An alignment leaving the count stage reaches the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_reg.valid) |=> out_valid_reg)
        else $error("alignment lost before the output register");

endmodule

// ===== hw/rtl/kmsm_cell.sv =====
// ============================================================================
// kmsm_cell: one position of the matcher row
// Holds one window byte that moves on to the neighbor on every text byte,
// one pattern byte, and the registered mismatch flag of this position.
// ============================================================================
module kmsm_cell #(
    parameter int INDEX = 0,
    parameter int MW    = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kmsm_pkg::cell_ctrl_t ctrl,
    input  logic                 load,
    input  kmsm_pkg::symbol_t    load_symbol,
    input  kmsm_pkg::symbol_t    text_in,
    output kmsm_pkg::symbol_t    text_out,
    input  kmsm_pkg::symbol_t    aligned,
    input  logic [MW-1:0]        used_length,
    output logic                 mismatch
);
    import kmsm_pkg::*;

    symbol_t text_reg;
    symbol_t pattern_reg;
    logic    mismatch_reg;
    logic    in_use;

    // Window byte: takes the neighbor's byte when a text byte arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            text_reg <= text_in;
        end
    end

    // Pattern byte and mismatch flag carry no reset.
    assign in_use = (MW'(INDEX) < used_length);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pattern_reg <= load_symbol;
        end
        if (ctrl.compare)
        begin
            mismatch_reg <= in_use && (pattern_reg != aligned);
        end
    end

    assign text_out = text_reg;
    assign mismatch = mismatch_reg;

endmodule

// ===== hw/rtl/kmsm_align.sv =====
// ============================================================================
// kmsm_align: window alignment network
// Brings window byte (length-1-j) in front of cell j with a logarithmic
// shifter over the reversed window, so each cell sees its text byte.
// ============================================================================
module kmsm_align #(
    parameter int PATTERN_MAX = 64,
    parameter int MW          = 7
) (
    input  kmsm_pkg::symbol_t window [PATTERN_MAX],
    input  logic [MW-1:0]     used_length,
    output kmsm_pkg::symbol_t aligned [PATTERN_MAX]
);
    import kmsm_pkg::*;

    localparam int SW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [MW-1:0] MAX_LEN = MW'(PATTERN_MAX);

    logic [SW-1:0] shift;
    symbol_t       stage [SW+1][PATTERN_MAX];

    // Shift amount is the number of unused positions.
    assign shift = SW'(MAX_LEN - used_length);

    // Reverse the window, then shift down by one power of two per level.
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            stage[0][i] = window[PATTERN_MAX-1-i];
        end
        for (int k = 0; k < SW; k++)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (!shift[k])
                begin
                    stage[k+1][i] = stage[k][i];
                end
                else if (i + (1 << k) < PATTERN_MAX)
                begin
                    stage[k+1][i] = stage[k][i + (1 << k)];
                end
                else
                begin
                    stage[k+1][i] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            aligned[i] = stage[SW][i];
        end
    end

endmodule

// ===== hw/rtl/kmsm_count.sv =====
// ============================================================================
// kmsm_count: mismatch flag counter
// Counts flags in groups of eight into registers, then sums the groups.
// ============================================================================
module kmsm_count #(
    parameter int PATTERN_MAX = 64,
    parameter int MW          = 7
) (
    input  logic                   clk,
    input  logic                   advance,
    input  logic [PATTERN_MAX-1:0] flags,
    output logic [MW-1:0]          total
);
    import kmsm_pkg::*;

    localparam int GROUPS = (PATTERN_MAX + 7) / 8;
    localparam int GW     = 4;

    logic [GW-1:0] group_next [GROUPS];
    logic [GW-1:0] group_reg  [GROUPS];

    // Population count of each group of eight flags.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (g * 8 + b < PATTERN_MAX)
                begin
                    group_next[g] = group_next[g] + GW'(flags[g * 8 + b]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            group_reg <= group_next;
        end
    end

    // Sum of the group counts; never exceeds the row length.
    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total = total + MW'(group_reg[g]);
        end
    end

endmodule
